// File: src/spectral_angle_match_top_defines.svh
// Assertion macros used by the spectral angle match controller.
`ifndef SPECTRAL_ANGLE_MATCH_TOP_DEFINES_SVH
`define SPECTRAL_ANGLE_MATCH_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define SAM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define SAM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/sam_pkg.sv
// Package with the types, constants and helpers of the spectral angle match block.
package sam_pkg;

	localparam int MAX_BANDS = 256;
	localparam int BAND_W    = 8;
	localparam int SAMPLE_W  = 16;
	localparam int THR_W     = 17;
	localparam logic [THR_W-1:0] THR_RESET = 17'd31704;

	localparam int PROD_W = 2 * SAMPLE_W;
	localparam int ACC_W  = 40;

	// Shared multiplier: A operand times B operand, B taken one digit per cycle.
	localparam int DIG_W      = 8;
	localparam int MUL_A_W    = THR_W + ACC_W;
	localparam int MUL_B_W    = ACC_W;
	localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
	localparam int MUL_DIGITS = (MUL_B_W + DIG_W - 1) / DIG_W;
	localparam int CNT_W      = $clog2(MUL_DIGITS);
	localparam int LHS_W      = 2 * ACC_W;
	localparam int Q_SHIFT    = 16;

	localparam logic OP_REF   = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_ACC,
		S_CHECK,
		S_MLOAD,
		S_MSTEP,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		MUL_DOT,
		MUL_CXE,
		MUL_RHS
	} mul_sel_t;

	typedef struct packed {
		logic     ref_wr;
		logic     ref_rd;
		logic     cap;
		logic     prod_en;
		logic     acc_en;
		logic     acc_clr;
		logic     mul_load;
		logic     mul_step;
		mul_sel_t mul_sel;
		logic     out_load;
	} sam_cmd_t;

	typedef struct packed {
		logic last;
		logic zero;
	} sam_sts_t;

	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
			input logic [PROD_W-1:0] b);
		logic [ACC_W:0] sum;
		sum = {1'b0, a} + (ACC_W+1)'(b);
		return sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
	endfunction

endpackage

// File: src/sam_if.sv
// Channel interfaces of the spectral angle match block.
interface sam_pix_if;
	logic                                valid;
	logic                                ready;
	logic                                op;
	logic [sam_pkg::BAND_W-1:0]          band;
	logic signed [sam_pkg::SAMPLE_W-1:0] value;
	logic                                last;

	modport source (output valid, op, band, value, last, input ready);
	modport sink (input valid, op, band, value, last, output ready);
endinterface

interface sam_res_if;
	logic valid;
	logic ready;
	logic angle_at_or_above;
	logic zero_norm;

	modport source (output valid, angle_at_or_above, zero_norm, input ready);
	modport sink (input valid, angle_at_or_above, zero_norm, output ready);
endinterface

interface sam_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [sam_pkg::THR_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: src/spectral_angle_match_top.sv
// Top level of the spectral angle match block: controller, datapath and channel wiring.
//
//   channel | dir | payload                        | transaction
//   --------+-----+--------------------------------+--------------------------
//   pix     | in  | op, band, value, last          | reference write or pixel band
//   res     | out | angle_at_or_above, zero_norm   | one per pixel (last band)
//   cfg     | in  | data (cos_sq_threshold, Q16)   | threshold register write
//
// A reference write is done on acceptance; a pixel band goes through accept, memory read
// and accumulate, and pix is ready again in idle. A last band adds a check, three
// products on the shared 57 x 8 bit multiplier (a load and five digit steps each) and a
// result step, or just the check and the result when an energy is zero. Reset clears the
// controller and accumulators and sets the threshold to 31704, not the reference memory.
// A stalled res parks one result in its register; the next last band then holds pix off.
module spectral_angle_match_top (
	input logic        clk,
	input logic        arst_n,
	sam_pix_if.sink    pix,
	sam_res_if.source  res,
	sam_cfg_if.sink    cfg
);

	sam_pkg::sam_cmd_t cmd;
	sam_pkg::sam_sts_t sts;

	// cfg is always ready; the user must write the threshold only while idle (unenforced).
	assign cfg.ready = 1'b1;

	// The controller owns the handshakes and the sequencing of the datapath.
	sam_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix.valid),
		.pix_op    (pix.op),
		.pix_ready (pix.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the reference memory, accumulators, multiplier and result register.
	sam_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.band      (pix.band),
		.value     (pix.value),
		.last      (pix.last),
		.cfg_we    (cfg.valid && cfg.ready),
		.cfg_data  (cfg.data),
		.flag      (res.angle_at_or_above),
		.zero_norm (res.zero_norm)
	);

endmodule

// File: src/sam_ram.sv
// Generic single-port-write, registered-read RAM.
module sam_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/sam_datapath.sv
// Datapath: reference memory, band products, accumulators, shared multiplier and compare.
module sam_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sam_pkg::sam_cmd_t                   cmd,
	output sam_pkg::sam_sts_t                   sts,
	input  logic [sam_pkg::BAND_W-1:0]          band,
	input  logic signed [sam_pkg::SAMPLE_W-1:0] value,
	input  logic                                last,
	input  logic                                cfg_we,
	input  logic [sam_pkg::THR_W-1:0]           cfg_data,
	output logic                                flag,
	output logic                                zero_norm
);

	logic [sam_pkg::THR_W-1:0]          thr_q;
	logic signed [sam_pkg::SAMPLE_W-1:0] x_q;
	logic                                last_q;
	logic [sam_pkg::SAMPLE_W-1:0]        ref_rdata;
	logic signed [sam_pkg::SAMPLE_W-1:0] y;
	logic signed [sam_pkg::PROD_W-1:0]   xy;
	logic signed [sam_pkg::PROD_W-1:0]   xx;
	logic signed [sam_pkg::PROD_W-1:0]   yy;
	logic [sam_pkg::PROD_W-1:0]          xy_mag_s2;
	logic [sam_pkg::PROD_W-1:0]          xx_s2;
	logic [sam_pkg::PROD_W-1:0]          yy_s2;
	logic [sam_pkg::ACC_W-1:0]           dot_q;
	logic [sam_pkg::ACC_W-1:0]           pxe_q;
	logic [sam_pkg::ACC_W-1:0]           rfe_q;
	logic [sam_pkg::MUL_A_W-1:0]         mul_a_q;
	logic [sam_pkg::MUL_B_W-1:0]         mul_b_q;
	logic [sam_pkg::MUL_P_W-1:0]         mul_p_q;
	logic [sam_pkg::LHS_W-1:0]           lhs_q;
	logic [sam_pkg::DIG_W-1:0]           digit;
	logic [sam_pkg::MUL_A_W+sam_pkg::DIG_W-1:0] pp;
	logic [sam_pkg::MUL_P_W-1:0]         lhs_ext;
	logic                                le;

	sam_ram #(
		.WIDTH(sam_pkg::SAMPLE_W),
		.DEPTH(sam_pkg::MAX_BANDS)
	) u_ref_ram (
		.clk   (clk),
		.we    (cmd.ref_wr),
		.waddr (band),
		.wdata (value),
		.re    (cmd.ref_rd),
		.raddr (band),
		.rdata (ref_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= sam_pkg::THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			x_q    <= value;
			last_q <= last;
		end
	end

	// Band products; the magnitude of x*y never exceeds 2^30, so the negation is safe.
	assign y  = $signed(ref_rdata);
	assign xy = x_q * y;
	assign xx = x_q * x_q;
	assign yy = y * y;

	always_ff @(posedge clk) begin
		if (cmd.prod_en) begin
			xy_mag_s2 <= xy[sam_pkg::PROD_W-1] ? $unsigned(-xy) : $unsigned(xy);
			xx_s2     <= $unsigned(xx);
			yy_s2     <= $unsigned(yy);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			pxe_q <= '0;
			rfe_q <= '0;
		end else if (cmd.acc_clr) begin
			dot_q <= '0;
			pxe_q <= '0;
			rfe_q <= '0;
		end else if (cmd.acc_en) begin
			dot_q <= sam_pkg::sat_add(dot_q, xy_mag_s2);
			pxe_q <= sam_pkg::sat_add(pxe_q, xx_s2);
			rfe_q <= sam_pkg::sat_add(rfe_q, yy_s2);
		end
	end

	// Digit-serial multiplier: most significant digit of B first, P shifts left each step.
	assign digit = mul_b_q[sam_pkg::MUL_B_W-1 -: sam_pkg::DIG_W];
	assign pp    = mul_a_q * digit;

	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			mul_p_q <= '0;
			unique case (cmd.mul_sel)
				sam_pkg::MUL_DOT: begin
					mul_a_q <= sam_pkg::MUL_A_W'(dot_q);
					mul_b_q <= dot_q;
				end
				sam_pkg::MUL_CXE: begin
					mul_a_q <= sam_pkg::MUL_A_W'(thr_q);
					mul_b_q <= pxe_q;
					lhs_q   <= mul_p_q[sam_pkg::LHS_W-1:0];
				end
				sam_pkg::MUL_RHS: begin
					mul_a_q <= mul_p_q[sam_pkg::MUL_A_W-1:0];
					mul_b_q <= rfe_q;
				end
				default: begin
					mul_a_q <= '0;
					mul_b_q <= '0;
				end
			endcase
		end else if (cmd.mul_step) begin
			mul_p_q <= {mul_p_q[sam_pkg::MUL_P_W-sam_pkg::DIG_W-1:0], {sam_pkg::DIG_W{1'b0}}}
				+ sam_pkg::MUL_P_W'(pp);
			mul_b_q <= {mul_b_q[sam_pkg::MUL_B_W-sam_pkg::DIG_W-1:0], {sam_pkg::DIG_W{1'b0}}};
		end
	end

	assign lhs_ext = {{(sam_pkg::MUL_P_W-sam_pkg::LHS_W-sam_pkg::Q_SHIFT){1'b0}}, lhs_q,
		{sam_pkg::Q_SHIFT{1'b0}}};
	assign le = lhs_ext <= mul_p_q;

	assign sts.last = last_q;
	assign sts.zero = (pxe_q == '0) || (rfe_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			flag      <= le && !sts.zero;
			zero_norm <= sts.zero;
		end
	end

endmodule

// File: src/sam_ctrl.sv
// Controller state machine sequencing band accumulation, the final products and the result.
`include "spectral_angle_match_top_defines.svh"

module sam_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	input  logic              pix_op,
	output logic              pix_ready,
	output logic              res_valid,
	input  logic              res_ready,
	input  sam_pkg::sam_sts_t sts,
	output sam_pkg::sam_cmd_t cmd
);

	sam_pkg::state_t             state_q, state_d;
	sam_pkg::mul_sel_t           sel_q, sel_d;
	logic [sam_pkg::CNT_W-1:0]   cnt_q, cnt_d;
	logic                        res_valid_q, res_valid_d;
	logic                        res_free;

	assign res_free  = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sam_pkg::S_IDLE;
			sel_q       <= sam_pkg::MUL_DOT;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			sel_q       <= sel_d;
			cnt_q       <= cnt_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		sel_d     = sel_q;
		cnt_d     = cnt_q;
		pix_ready = 1'b0;
		cmd       = '0;
		cmd.mul_sel = sel_q;

		unique case (state_q)
			sam_pkg::S_IDLE: begin
				pix_ready = 1'b1;
				if (pix_valid) begin
					if (pix_op == sam_pkg::OP_PIXEL) begin
						cmd.ref_rd = 1'b1;
						cmd.cap    = 1'b1;
						state_d    = sam_pkg::S_READ;
					end else begin
						cmd.ref_wr = 1'b1;
					end
				end
			end
			sam_pkg::S_READ: begin
				cmd.prod_en = 1'b1;
				state_d     = sam_pkg::S_ACC;
			end
			sam_pkg::S_ACC: begin
				cmd.acc_en = 1'b1;
				state_d    = sts.last ? sam_pkg::S_CHECK : sam_pkg::S_IDLE;
			end
			sam_pkg::S_CHECK: begin
				sel_d   = sam_pkg::MUL_DOT;
				state_d = sts.zero ? sam_pkg::S_DONE : sam_pkg::S_MLOAD;
			end
			sam_pkg::S_MLOAD: begin
				cmd.mul_load = 1'b1;
				cnt_d        = '0;
				state_d      = sam_pkg::S_MSTEP;
			end
			sam_pkg::S_MSTEP: begin
				cmd.mul_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == sam_pkg::CNT_W'(sam_pkg::MUL_DIGITS - 1)) begin
					unique case (sel_q)
						sam_pkg::MUL_DOT: begin
							sel_d   = sam_pkg::MUL_CXE;
							state_d = sam_pkg::S_MLOAD;
						end
						sam_pkg::MUL_CXE: begin
							sel_d   = sam_pkg::MUL_RHS;
							state_d = sam_pkg::S_MLOAD;
						end
						sam_pkg::MUL_RHS: begin
							state_d = sam_pkg::S_DONE;
						end
						default: begin
							state_d = sam_pkg::S_IDLE;
						end
					endcase
				end
			end
			sam_pkg::S_DONE: begin
				if (res_free) begin
					cmd.out_load = 1'b1;
					cmd.acc_clr  = 1'b1;
					state_d      = sam_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sam_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		if (cmd.out_load) begin
			res_valid_d = 1'b1;
		end else if (res_ready) begin
			res_valid_d = 1'b0;
		end else begin
			res_valid_d = res_valid_q;
		end
	end

	`SAM_ASSERT_SAME(a_load_free, cmd.out_load, !res_valid_q || res_ready, "result overwritten")
	`SAM_ASSERT_NEXT(a_pixel_read, pix_valid && pix_ready && (pix_op == sam_pkg::OP_PIXEL), state_q == sam_pkg::S_READ, "pixel transaction did not start a read")
	`SAM_ASSERT_SAME(a_cnt_range, state_q == sam_pkg::S_MSTEP, cnt_q < sam_pkg::CNT_W'(sam_pkg::MUL_DIGITS), "digit count out of range")
	`SAM_ASSERT_NEXT(a_out_valid, cmd.out_load, res_valid_q, "loaded result not presented")

endmodule

// File: dv/sam_angle_checker.sv
// Checker that predicts the spectral angle verdicts and compares them with the result channel.
module sam_angle_checker import sam_pkg::*; (
	input logic clk,
	input logic arst_n,
	sam_pix_if  pix,
	sam_res_if  res,
	sam_cfg_if  cfg,
	output int  mismatches,
	output int  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [64:0] ACC_CAP = (65'd1 << ACC_W) - 65'd1;

	typedef struct packed {
		logic angle_at_or_above;
		logic zero_norm;
	} verdict_t;

	logic signed [SAMPLE_W-1:0] ref_table [MAX_BANDS];
	logic [ACC_W-1:0] dot_sum;
	logic [ACC_W-1:0] pix_energy;
	logic [ACC_W-1:0] ref_energy;
	logic [THR_W-1:0] cos_sq_thr;
	verdict_t expected_verdicts [$];
	int error_total = 0;
	int queued = 0;

	assign mismatches  = error_total;
	assign outstanding = queued;

	function automatic logic [ACC_W-1:0] clamp_add(input logic [ACC_W-1:0] acc,
			input logic [63:0] term);
		logic [64:0] sum;
		sum = 65'(acc) + 65'(term);
		return (sum > ACC_CAP) ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
	endfunction

	// Exact test of dot^2 * 2^16 <= C * Xe * Ye; all terms fit well within 128 bits.
	function automatic verdict_t angle_verdict();
		verdict_t v;
		logic [127:0] lhs;
		logic [127:0] rhs;
		v.zero_norm = (pix_energy == '0) || (ref_energy == '0);
		lhs = (128'(dot_sum) * 128'(dot_sum)) << Q_SHIFT;
		rhs = 128'(cos_sq_thr) * 128'(pix_energy) * 128'(ref_energy);
		v.angle_at_or_above = !v.zero_norm && (lhs <= rhs);
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t got;
		verdict_t want;
		longint x;
		longint y;
		longint prod;
		if (!arst_n) begin
			dot_sum    = '0;
			pix_energy = '0;
			ref_energy = '0;
			cos_sq_thr = THR_RESET;
			expected_verdicts.delete();
			queued = 0;
		end else begin
			if (res.valid && res.ready) begin
				got.angle_at_or_above = res.angle_at_or_above;
				got.zero_norm         = res.zero_norm;
				if (expected_verdicts.size() == 0) begin
					if (error_total < 10)
						$display("ERROR %0t: result angle_at_or_above=%0b zero_norm=%0b with none expected",
							$realtime, got.angle_at_or_above, got.zero_norm);
					error_total++;
				end else begin
					want = expected_verdicts.pop_front();
					if (got.angle_at_or_above !== want.angle_at_or_above ||
							got.zero_norm !== want.zero_norm) begin
						if (error_total < 10)
							$display("ERROR %0t: expected angle_at_or_above=%0b zero_norm=%0b, got %0b %0b",
								$realtime, want.angle_at_or_above, want.zero_norm,
								got.angle_at_or_above, got.zero_norm);
						error_total++;
					end
				end
			end
			if (cfg.valid && cfg.ready)
				cos_sq_thr = cfg.data;
			if (pix.valid && pix.ready) begin
				if (pix.op == OP_REF) begin
					ref_table[pix.band] = pix.value;
				end else begin
					x = longint'(pix.value);
					y = longint'(ref_table[pix.band]);
					prod = x * y;
					dot_sum    = clamp_add(dot_sum, 64'(prod < 0 ? -prod : prod));
					pix_energy = clamp_add(pix_energy, 64'(x * x));
					ref_energy = clamp_add(ref_energy, 64'(y * y));
					if (pix.last) begin
						expected_verdicts.push_back(angle_verdict());
						dot_sum    = '0;
						pix_energy = '0;
						ref_energy = '0;
					end
				end
			end
			queued = expected_verdicts.size();
		end
	end

endmodule

// File: dv/tb_spectral_angle_match_top.sv
// Testbench top for the spectral angle match block: stimulus, receiver stalls and verdict.
module tb_spectral_angle_match_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sam_pkg::*;

	// The run ends here at the latest; the slowest legal run is far below this.
	localparam int CYCLE_LIMIT = 600000;
	// Wait after the final result, so that the block has finished any band still in
	// flight and is certainly idle again.
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS   = 114;

	typedef enum int {
		RDY_ALWAYS,
		RDY_MOSTLY,
		RDY_RARELY,
		RDY_BLOCKED
	} ready_mode_t;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   cycle_count;
	int   burst_left;
	int   items_sent;
	bit   steady_sender;

	// Stimulus-side copy of the reference table. It only steers the generator: pixel
	// bands are drawn from loaded entries, and some pixels are made to resemble it.
	logic signed [SAMPLE_W-1:0] ref_shadow [MAX_BANDS];
	bit band_loaded [MAX_BANDS];

	sam_pix_if pix ();
	sam_res_if res ();
	sam_cfg_if cfg ();

	spectral_angle_match_top u_top (
		.clk,
		.arst_n,
		.pix (pix.sink),
		.res (res.source),
		.cfg (cfg.sink)
	);

	sam_angle_checker u_checker (
		.clk,
		.arst_n,
		.pix (pix),
		.res (res),
		.cfg (cfg),
		.mismatches,
		.outstanding
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The watchdog: if the run has not come to its end by the limit, it fails.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	// The receiver keeps changing its mood: sometimes it takes every result,
	// sometimes it stalls lightly, sometimes it hardly ever accepts.
	initial begin : res_stall
		ready_mode_t mode;
		int span;
		res.ready = 1'b0;
		forever begin
			mode = ready_mode_t'($urandom_range(0, 3));
			span = $urandom_range(20, 200);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					RDY_ALWAYS:  res.ready <= 1'b1;
					RDY_MOSTLY:  res.ready <= ($urandom_range(0, 3) != 0);
					RDY_RARELY:  res.ready <= ($urandom_range(0, 3) == 0);
					default:     res.ready <= ($urandom_range(0, 15) == 0);
				endcase
			end
		end
	end

	// Sends one transaction on the pixel channel. It is entered at a falling edge and
	// returns at the falling edge after acceptance with valid still high, so that a
	// following item keeps valid up without a lower-and-raise in one time step. The
	// sender works in bursts; between them valid drops for a random gap unless steady.
	task automatic send_item(input logic op_i, input logic [BAND_W-1:0] band_i,
			input logic signed [SAMPLE_W-1:0] value_i, input logic last_i);
		int gap;
		if (burst_left == 0) begin
			gap = steady_sender ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				pix.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		pix.valid <= 1'b1;
		pix.op    <= op_i;
		pix.band  <= band_i;
		pix.value <= value_i;
		pix.last  <= last_i;
		if (op_i == OP_REF) begin
			ref_shadow[band_i]  = value_i;
			band_loaded[band_i] = 1'b1;
		end
		do @(posedge clk); while (!pix.ready);
		burst_left--;
		items_sent++;
		@(negedge clk);
	endtask

	// Drops valid and waits until every expected result has arrived, then lets the
	// block finish any band that produces no result.
	task automatic drain();
		pix.valid <= 1'b0;
		burst_left = 0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Threshold register write; only called while the block is idle.
	task automatic write_threshold(input logic [THR_W-1:0] thr);
		cfg.valid <= 1'b1;
		cfg.data  <= thr;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Sample with a bias toward the extremes, zero and small magnitudes.
	function automatic logic signed [SAMPLE_W-1:0] any_sample();
		case ($urandom_range(0, 7))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2:       return '0;
			3:       return 16'(int'($urandom_range(0, 32)) - 16);
			default: return 16'($urandom());
		endcase
	endfunction

	// Sample close to a scaled copy of the reference entry, possibly with its sign
	// flipped; this pushes the angle toward zero so that both verdicts occur.
	function automatic logic signed [SAMPLE_W-1:0] near_sample(input logic [BAND_W-1:0] b);
		int v;
		v = int'(ref_shadow[b]) >>> $urandom_range(0, 3);
		if ($urandom_range(0, 1) != 0)
			v = -v;
		if ($urandom_range(0, 2) != 0)
			v += int'($urandom_range(0, 64)) - 32;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return 16'(v);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] big_sample();
		int m;
		m = $urandom_range(30000, 32767);
		if ($urandom_range(0, 7) == 0)
			return 16'sh8000;
		return ($urandom_range(0, 1) != 0) ? 16'(-m) : 16'(m);
	endfunction

	// Reference entries are undefined until written, so pixel bands only ever
	// address entries that have been loaded.
	function automatic logic [BAND_W-1:0] loaded_band();
		logic [BAND_W-1:0] b;
		do b = BAND_W'($urandom()); while (!band_loaded[b]);
		return b;
	endfunction

	// One pixel of a given band count. Now and then a reference rewrite slips in
	// between its bands. With close cleared the pixel has no end mark and runs on
	// into the next one.
	task automatic send_pixel(input int bands, input bit similar, input bit close);
		logic [BAND_W-1:0] b;
		for (int i = 0; i < bands; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_item(OP_REF, BAND_W'($urandom()), any_sample(), 1'($urandom()));
			b = loaded_band();
			send_item(OP_PIXEL, b, similar ? near_sample(b) : any_sample(),
				(i == bands - 1) && close);
		end
	endtask

	// Three pixels that sit at fixed points of the compare: an exactly parallel
	// one (equality when the threshold is 1.0), one with cos^2 of one half, and an
	// orthogonal one whose dot product is zero.
	task automatic probe_pixels();
		send_item(OP_REF, 8'd1, 16'sd0, 1'b0);
		send_item(OP_REF, 8'd2, 16'sd1, 1'b0);
		send_item(OP_REF, 8'd3, -16'sd1, 1'b0);
		send_item(OP_PIXEL, 8'd3, -16'sd9, 1'b1);
		send_item(OP_PIXEL, 8'd3, 16'sd7, 1'b0);
		send_item(OP_PIXEL, 8'd2, 16'sd0, 1'b1);
		send_item(OP_PIXEL, 8'd1, 16'sd5, 1'b0);
		send_item(OP_PIXEL, 8'd2, 16'sd0, 1'b1);
	endtask

	// Mostly well-formed pixels of random content, some long, some without an end
	// mark, mixed with stray reference writes. The phase always closes its last
	// pixel, so the threshold is never changed halfway through one.
	task automatic random_phase(input int quota);
		int start;
		start = items_sent;
		while (items_sent - start < quota) begin
			case ($urandom_range(0, 9))
				0:       send_item(OP_REF, BAND_W'($urandom()), any_sample(), 1'($urandom()));
				1:       send_pixel($urandom_range(1, 40), $urandom_range(0, 1),
						$urandom_range(0, 3) != 0);
				default: send_pixel($urandom_range(1, 8), $urandom_range(0, 1),
						$urandom_range(0, 7) != 0);
			endcase
			// Occasionally hold off until every pending result has come back.
			if ($urandom_range(0, 59) == 0)
				drain();
		end
		send_pixel(1, 1'b0, 1'b1);
	endtask

	// A pixel of near full-scale samples on the top four bands.
	task automatic full_scale_pixel(input int bands);
		for (int k = 0; k < 4; k++)
			send_item(OP_REF, BAND_W'(252 + k), big_sample(), 1'b0);
		for (int i = 0; i < bands; i++)
			send_item(OP_PIXEL, BAND_W'(252 + $urandom_range(0, 3)), big_sample(),
				i == bands - 1);
	endtask

	initial begin : stimulus
		arst_n     = 1'b0;
		pix.valid  = 1'b0;
		pix.op     = OP_REF;
		pix.band   = '0;
		pix.value  = '0;
		pix.last   = 1'b0;
		cfg.valid  = 1'b0;
		cfg.data   = '0;
		burst_left = 0;
		items_sent = 0;
		steady_sender = 1'b0;
		for (int i = 0; i < MAX_BANDS; i++)
			band_loaded[i] = 1'b0;

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, run with the threshold left at its reset value.
		send_item(OP_REF, 8'd0, 16'sh7FFF, 1'b0);
		send_item(OP_REF, 8'd255, 16'sh8000, 1'b0);
		// A reference write marked last must not produce a result.
		send_item(OP_REF, 8'd4, 16'sd100, 1'b1);
		probe_pixels();
		// Parallel pixel at full scale in both signs.
		send_item(OP_PIXEL, 8'd0, 16'sh8000, 1'b1);
		send_item(OP_PIXEL, 8'd255, 16'sh7FFF, 1'b0);
		send_item(OP_PIXEL, 8'd0, 16'sh7FFF, 1'b1);
		// Zero reference energy, then zero pixel energy.
		send_item(OP_PIXEL, 8'd1, 16'sd5, 1'b1);
		send_item(OP_PIXEL, 8'd2, 16'sd0, 1'b1);
		// A band with no end mark that carries over into the next pixel.
		send_item(OP_PIXEL, 8'd4, -16'sd1, 1'b0);
		send_item(OP_PIXEL, 8'd0, 16'sd1, 1'b1);
		random_phase(PHASE_ITEMS);
		drain();

		// Threshold zero: only an orthogonal pixel is at or above the angle.
		write_threshold(17'd0);
		probe_pixels();
		random_phase(PHASE_ITEMS);
		drain();

		// Threshold of exactly 1.0, with the sender never idling.
		steady_sender = 1'b1;
		write_threshold(17'd65536);
		probe_pixels();
		random_phase(PHASE_ITEMS);
		drain();
		steady_sender = 1'b0;

		// Largest register value, above 1.0: the compare then nearly always holds.
		write_threshold(17'h1FFFF);
		probe_pixels();
		full_scale_pixel(8);
		random_phase(PHASE_ITEMS);
		drain();

		write_threshold(17'd1);
		probe_pixels();
		random_phase(PHASE_ITEMS);
		drain();

		steady_sender = 1'b1;
		write_threshold(17'd65535);
		probe_pixels();
		random_phase(PHASE_ITEMS);
		drain();
		steady_sender = 1'b0;

		write_threshold(THR_W'($urandom_range(0, 131071)));
		probe_pixels();
		random_phase(PHASE_ITEMS);
		drain();

		// Back to the reset value of the register.
		write_threshold(THR_RESET);
		probe_pixels();
		random_phase(PHASE_ITEMS);
		drain();

		if (mismatches == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: files.f
+incdir+src
src/sam_pkg.sv
src/sam_if.sv
src/sam_ram.sv
src/sam_datapath.sv
src/sam_ctrl.sv
src/spectral_angle_match_top.sv
dv/sam_angle_checker.sv
dv/tb_spectral_angle_match_top.sv
